### sv/rayaabb_pkg.sv
// ----------------------------------------------------------------------------
// rayaabb_pkg
// Shared constants and types of the ray / box intersection block.
// ----------------------------------------------------------------------------
package rayaabb_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DIST_BITS      = 32;
  localparam int NUM_AXES       = 3;
  localparam int OUT_TDATA_BITS = 40;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = 2;

  // Classification of one item, made by the front part.
  typedef struct packed {
    logic                orig_in;
    logic [NUM_AXES-1:0] try_lo;
    logic [NUM_AXES-1:0] try_hi;
  } cls_t;

endpackage

### sv/rayaabb_front.sv
// ----------------------------------------------------------------------------
// rayaabb_front
// Classifies an item: origin inside test, which face of each axis is tried,
// and the magnitudes of plane distance and direction for each axis.
// ----------------------------------------------------------------------------
module rayaabb_front #(
  parameter int COORD_BITS = rayaabb_pkg::COORD_BITS_DEF
) (
  input  logic [4*rayaabb_pkg::NUM_AXES*COORD_BITS-1:0] coords,
  output rayaabb_pkg::cls_t                             cls,
  output logic [rayaabb_pkg::NUM_AXES*COORD_BITS-1:0]   num,
  output logic [rayaabb_pkg::NUM_AXES*COORD_BITS-1:0]   den
);

  localparam int C  = COORD_BITS;
  localparam int NA = rayaabb_pkg::NUM_AXES;

  logic [NA-1:0] in_ax;
  logic [NA-1:0] try_lo;
  logic [NA-1:0] try_hi;

  for (genvar a = 0; a < NA; a++) begin : g_ax
    logic signed [C-1:0] o, d, lo, hi;
    logic signed [C:0]   dlo, dhi, dneg;

    assign o    = coords[a*C +: C];
    assign d    = coords[(NA+a)*C +: C];
    assign lo   = coords[(2*NA+a)*C +: C];
    assign hi   = coords[(3*NA+a)*C +: C];
    assign dlo  = {lo[C-1], lo} - {o[C-1], o};
    assign dhi  = {o[C-1], o} - {hi[C-1], hi};
    assign dneg = -{d[C-1], d};

    assign in_ax[a]  = (o > lo) && (o < hi);
    assign try_lo[a] = (o <= lo) && (d > 0);
    assign try_hi[a] = (o >= hi) && (d < 0);

    // The selected difference is non-negative and below 2^C whenever a face is tried.
    assign num[a*C +: C] = try_lo[a] ? dlo[C-1:0] : dhi[C-1:0];
    assign den[a*C +: C] = try_hi[a] ? dneg[C-1:0] : (try_lo[a] ? d : C'(1));
  end

  assign cls.orig_in = &in_ax;
  assign cls.try_lo  = try_lo;
  assign cls.try_hi  = try_hi;

endmodule

### sv/rayaabb_fifo.sv
// ----------------------------------------------------------------------------
// rayaabb_fifo
// Short queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module rayaabb_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = rayaabb_pkg::FIFO_AW;

  logic [W-1:0]  mem [rayaabb_pkg::FIFO_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(rayaabb_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

### sv/rayaabb_div.sv
// ----------------------------------------------------------------------------
// rayaabb_div
// Pipelined restoring divider, one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
module rayaabb_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [NW-1:0] q
);

  logic [NW-1:0] nsh [NW];
  logic [DW-1:0] rem [NW];
  logic [NW-1:0] quo [NW];
  logic [DW-1:0] dd  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [NW-1:0] n_in, q_in;
    logic [DW-1:0] r_in, d_in;
    logic [DW:0]   trial, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign n_in = n;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = d;
    end else begin : g_rest
      assign n_in = nsh[k-1];
      assign q_in = quo[k-1];
      assign r_in = rem[k-1];
      assign d_in = dd[k-1];
    end

    // The remainder stays below the divisor, so a non-negative difference never
    // reaches the top bit and a borrow there means trial < divisor.
    assign trial = {r_in, n_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = ~diff[DW];

    always_ff @(posedge clk) begin
      if (en) begin
        nsh[k] <= n_in << 1;
        rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo[k] <= {q_in[NW-2:0], ge};
        dd[k]  <= d_in;
      end
    end
  end

  assign q = quo[NW-1];

endmodule

### sv/rayaabb_back.sv
// ----------------------------------------------------------------------------
// rayaabb_back
// Face distances, exact hit point checks, nearest face and output register.
// ----------------------------------------------------------------------------
module rayaabb_back #(
  parameter int COORD_BITS = rayaabb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rayaabb_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  rayaabb_pkg::cls_t                             in_cls,
  input  logic [4*rayaabb_pkg::NUM_AXES*COORD_BITS-1:0] in_coords,
  input  logic [rayaabb_pkg::NUM_AXES*COORD_BITS-1:0]   in_num,
  input  logic [rayaabb_pkg::NUM_AXES*COORD_BITS-1:0]   in_den,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic                                          hit,
  output logic [rayaabb_pkg::DIST_BITS-1:0]             distance
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NA   = rayaabb_pkg::NUM_AXES;
  localparam int DB   = rayaabb_pkg::DIST_BITS;
  localparam int QW   = C + F;
  localparam int HW   = (QW + 1) / 2;
  localparam int PWID = QW + C + 2;
  localparam int NC   = 4 * NA * C;
  localparam int EW   = (QW > DB) ? QW : DB;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Per-axis quotient t = num * 2^F / den.
  logic [QW-1:0] tq [NA];
  for (genvar a = 0; a < NA; a++) begin : g_div
    rayaabb_div #(.NW(QW), .DW(C)) u_div (
      .clk (clk),
      .en  (en),
      .n   ({in_num[a*C +: C], {F{1'b0}}}),
      .d   (in_den[a*C +: C]),
      .q   (tq[a])
    );
  end

  // Item data travels beside the divider stages.
  logic [QW-1:0]     v_line;
  logic [NC-1:0]     crd_line [QW];
  rayaabb_pkg::cls_t cls_line [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      crd_line[0] <= in_coords;
      cls_line[0] <= in_cls;
      for (int k = 1; k < QW; k++) begin
        crd_line[k] <= crd_line[k-1];
        cls_line[k] <= cls_line[k-1];
      end
    end
  end

  logic va, vb, vc;
  logic [NC-1:0]     crd_a, crd_b;
  rayaabb_pkg::cls_t cls_a, cls_b, cls_c;
  logic [QW-1:0]      t_a [NA];
  logic [QW-1:0]      t_b [NA];
  logic [QW-1:0]      t_c [NA];
  logic [HW+C-1:0]    mlo_a  [NA][2];
  logic [QW-HW+C-1:0] mhi_a  [NA][2];
  logic [QW+C-1:0]    prod_b [NA][2];
  logic               ok_c   [NA][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_line    <= '0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_line    <= {v_line[QW-2:0], in_valid};
      va        <= v_line[QW-1];
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crd_a <= crd_line[QW-1];
      crd_b <= crd_a;
      cls_a <= cls_line[QW-1];
      cls_b <= cls_a;
      cls_c <= cls_b;
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_ax
    always_ff @(posedge clk) begin
      if (en) begin
        t_a[a] <= tq[a];
        t_b[a] <= t_a[a];
        t_c[a] <= t_b[a];
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_chk
      localparam int K = (a + 1 + j) % NA;

      logic signed [C-1:0]    dk, ok_o, ok_lo, ok_hi;
      logic [C:0]             dneg;
      logic [C-1:0]           mag;
      logic signed [PWID-1:0] eo, elo, ehi, pr, pt;

      assign dk   = crd_line[QW-1][(NA+K)*C +: C];
      assign dneg = -{dk[C-1], dk};
      assign mag  = dk[C-1] ? dneg[C-1:0] : dk;

      // The product t * |d| is split in two halves of t.
      always_ff @(posedge clk) begin
        if (en) begin
          mlo_a[a][j]  <= (HW+C)'(tq[a][HW-1:0]) * (HW+C)'(mag);
          mhi_a[a][j]  <= (QW-HW+C)'(tq[a][QW-1:HW]) * (QW-HW+C)'(mag);
          prod_b[a][j] <= {mhi_a[a][j], {HW{1'b0}}} + (QW+C)'(mlo_a[a][j]);
        end
      end

      assign ok_o  = crd_b[K*C +: C];
      assign ok_lo = crd_b[(2*NA+K)*C +: C];
      assign ok_hi = crd_b[(3*NA+K)*C +: C];
      assign eo    = PWID'(ok_o) <<< F;
      assign elo   = PWID'(ok_lo) <<< F;
      assign ehi   = PWID'(ok_hi) <<< F;
      assign pr    = signed'({2'b00, prod_b[a][j]});
      assign pt    = crd_b[(NA+K)*C + C-1] ? (eo - pr) : (eo + pr);

      always_ff @(posedge clk) begin
        if (en) begin
          ok_c[a][j] <= !(pt < elo) && !(ehi < pt);
        end
      end
    end
  end

  // Nearest counting face; earlier axes win ties.
  logic          hit_next;
  logic [DB-1:0] dist_next;

  always_comb begin
    logic          cand;
    logic          found;
    logic [QW-1:0] best;
    logic [EW-1:0] be;
    found = 1'b0;
    best  = '0;
    for (int a = 0; a < NA; a++) begin
      cand = (cls_c.try_lo[a] || cls_c.try_hi[a]) && ok_c[a][0] && ok_c[a][1];
      if (cand && (!found || (t_c[a] < best))) begin
        found = 1'b1;
        best  = t_c[a];
      end
    end
    be = EW'(best);
    if (cls_c.orig_in) begin
      hit_next  = 1'b1;
      dist_next = '0;
    end else if (!found) begin
      hit_next  = 1'b0;
      dist_next = '0;
    end else if ((be >> DB) != '0) begin
      hit_next  = 1'b1;
      dist_next = '1;
    end else begin
      hit_next  = 1'b1;
      dist_next = be[DB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= hit_next;
      distance <= dist_next;
    end
  end

endmodule

### sv/ray_aabb_intersection.sv
// ----------------------------------------------------------------------------
// ray_aabb_intersection
// Ray against axis-aligned box test, nearest entry distance, fully pipelined.
// ----------------------------------------------------------------------------
// Input transfers on the s_ channel carry one ray and one box each; every
// input transfer yields exactly one output transfer on the m_ channel, in
// order, carrying a hit flag and the nearest distance (unsigned fixed point,
// saturated, zero when there is no hit).
// Throughput is one item per clock while m_tready keeps the pipe moving.
// The divider resolves one quotient bit per stage and is followed by
// two multiply stages, a compare stage and the output register.
// A four-entry queue sits between the classifier and the arithmetic pipe.
// When m_tready is low the whole arithmetic pipe holds; the queue keeps
// s_tready high until it fills.
// Synchronous reset empties the queue and drops every item in flight;
// m_tvalid is low and s_tready high right after reset.
// ----------------------------------------------------------------------------
module ray_aabb_intersection #(
  parameter int COORD_BITS = rayaabb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rayaabb_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_lo_x, box_lo_y,
  // box_lo_z, box_hi_x, box_hi_y, box_hi_z, then zero fill
  input  logic [((4*rayaabb_pkg::NUM_AXES*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hit, distance, then zero fill
  output logic [rayaabb_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

  localparam int C  = COORD_BITS;
  localparam int NA = rayaabb_pkg::NUM_AXES;
  localparam int NC = 4 * NA * C;
  localparam int DB = rayaabb_pkg::DIST_BITS;
  localparam int CW = $bits(rayaabb_pkg::cls_t);
  localparam int QD = CW + NC + 2 * NA * C;

  rayaabb_pkg::cls_t    f_cls, b_cls;
  logic [NA*C-1:0]      f_num, f_den, b_num, b_den;
  logic [NC-1:0]        b_coords;
  logic [QD-1:0]        q_out;
  logic                 q_full, q_empty, b_ready, hit;
  logic [DB-1:0]        distance;

  rayaabb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .coords (s_tdata[NC-1:0]),
    .cls    (f_cls),
    .num    (f_num),
    .den    (f_den)
  );

  assign s_tready = !q_full;

  rayaabb_fifo #(.W(QD)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s_tvalid && !q_full),
    .din   ({f_cls, f_den, f_num, s_tdata[NC-1:0]}),
    .full  (q_full),
    .pop   (!q_empty && b_ready),
    .dout  (q_out),
    .empty (q_empty)
  );

  assign {b_cls, b_den, b_num, b_coords} = q_out;

  rayaabb_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .in_ready  (b_ready),
    .in_cls    (b_cls),
    .in_coords (b_coords),
    .in_num    (b_num),
    .in_den    (b_den),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .hit       (hit),
    .distance  (distance)
  );

  assign m_tdata = {{(rayaabb_pkg::OUT_TDATA_BITS-DB-1){1'b0}}, distance, hit};

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[DB:1] == '0)
    else $error("miss reported with a nonzero distance");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipe or queue not empty after reset");

endmodule

### dv/ray_aabb_intersection_tb.sv
// ----------------------------------------------------------------------------
// ray_aabb_intersection_tb
// Self-checking bench for the ray / box intersection block.
// A short table of hand-picked rays (inside origin, face hits, saturation,
// zero directions, inverted boxes, field extremes) is followed by random
// rays aimed at small boxes plus raw random words. Every output transfer is
// compared with a table value or a bit-exact predictor, under random idling
// on both sides and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module ray_aabb_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB       = rayaabb_pkg::COORD_BITS_DEF;
  localparam int FB       = rayaabb_pkg::FRAC_BITS_DEF;
  localparam int DB       = rayaabb_pkg::DIST_BITS;
  localparam int IN_BITS  = ((4*rayaabb_pkg::NUM_AXES*CB+7)/8)*8;
  localparam int N_RAND   = 950;
  localparam int QUIET    = 100;
  localparam int WD_LIMIT = 5000;

  typedef logic [11:0][CB-1:0] ray_item_t;
  typedef struct packed {
    logic          hit;
    logic [DB-1:0] distance;
  } hit_res_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_BITS-1:0] s_tdata;
  logic [rayaabb_pkg::OUT_TDATA_BITS-1:0] m_tdata;

  ray_item_t items[$];
  logic      typed_row[$];
  hit_res_t  typed_res[$];
  hit_res_t  pending_hits[$];

  int n_items, sent, received, n_hits, errors, idle_cycles;
  int send_gap, recv_gap, long_hold;
  logic held_long;

  ray_aabb_intersection uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hit_res_t nearest_hit(ray_item_t it);
    logic signed [127:0] o[3], d[3], lo[3], hi[3];
    logic signed [127:0] t_w, p;
    logic [63:0] num, den, t, best;
    logic found, ok;
    hit_res_t r;
    for (int k = 0; k < 3; k++) begin
      o[k]  = $signed(it[k]);
      d[k]  = $signed(it[3+k]);
      lo[k] = $signed(it[6+k]);
      hi[k] = $signed(it[9+k]);
    end
    r = '0;
    if (o[0] > lo[0] && o[1] > lo[1] && o[2] > lo[2] &&
        o[0] < hi[0] && o[1] < hi[1] && o[2] < hi[2]) begin
      r.hit = 1'b1;
      return r;
    end
    found = 1'b0;
    best = '0;
    for (int ax = 0; ax < 3; ax++) begin
      for (int side = 0; side < 2; side++) begin
        if (side == 0) begin
          if (!(o[ax] <= lo[ax] && d[ax] > 0)) continue;
          num = 64'(lo[ax] - o[ax]);
          den = 64'(d[ax]);
        end else begin
          if (!(o[ax] >= hi[ax] && d[ax] < 0)) continue;
          num = 64'(o[ax] - hi[ax]);
          den = 64'(-d[ax]);
        end
        t = (num << FB) / den;
        t_w = $signed({64'd0, t});
        ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (k == ax) continue;
          p = (o[k] <<< FB) + d[k] * t_w;
          if (p < (lo[k] <<< FB) || p > (hi[k] <<< FB)) ok = 1'b0;
        end
        if (ok && (!found || t < best)) begin
          found = 1'b1;
          best = t;
        end
      end
    end
    r.hit = found;
    if (found) r.distance = (best > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : best[31:0];
    return r;
  endfunction

  function automatic ray_item_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                   int lx, int ly, int lz, int hx, int hy, int hz);
    ray_item_t it;
    it[0] = ox; it[1] = oy; it[2] = oz;
    it[3] = dx; it[4] = dy; it[5] = dz;
    it[6] = lx; it[7] = ly; it[8] = lz;
    it[9] = hx; it[10] = hy; it[11] = hz;
    return it;
  endfunction

  task automatic add_row(ray_item_t it, logic typed, logic h, logic [31:0] want_dist);
    hit_res_t r;
    r.hit = h;
    r.distance = want_dist;
    items.push_back(it);
    typed_row.push_back(typed);
    typed_res.push_back(r);
  endtask

  function automatic int small_coord(int span);
    return $urandom_range(0, 2*span) - span;
  endfunction

  task automatic build_stimulus();
    ray_item_t it;
    int c, s, sel, tmp;
    localparam int ONE = 32'h0001_0000;
    localparam int MN  = 32'h8000_0000;
    localparam int MX  = 32'h7FFF_FFFF;
    // Directed table.
    add_row(mk(0,0,0, 0,0,0, -ONE,-ONE,-ONE, ONE,ONE,ONE), 1, 1, 0);
    add_row(mk(0,0,0, 0,0,0, 0,0,0, 0,0,0), 1, 0, 0);
    // Degenerate boxes with the origin on every plane: a face is met at t zero.
    add_row(mk(MN,MN,MN, MN,MN,MN, MN,MN,MN, MN,MN,MN), 1, 1, 0);
    add_row(mk(MX,MX,MX, MX,MX,MX, MX,MX,MX, MX,MX,MX), 1, 1, 0);
    add_row(mk(-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1), 0, 0, 0);
    // Origin far outside, direction of one LSB: t saturates.
    add_row(mk(MN,0,0, 1,0,0, MX,MN,MN, MX,MX,MX), 1, 1, 32'hFFFF_FFFF);
    add_row(mk(-2*ONE,0,0, ONE,0,0, 0,-ONE,-ONE, ONE,ONE,ONE), 1, 1, 2*ONE);
    add_row(mk(3*ONE,0,0, -ONE,0,0, 0,-ONE,-ONE, ONE,ONE,ONE), 1, 1, 2*ONE);
    add_row(mk(0,-2*ONE,0, 0,ONE,0, -ONE,0,-ONE, ONE,ONE,ONE), 1, 1, 2*ONE);
    add_row(mk(0,0,3*ONE, 0,0,-ONE, -ONE,-ONE,0, ONE,ONE,ONE), 1, 1, 2*ONE);
    // Hit point exactly on an edge of the face: inclusive bounds.
    add_row(mk(-2*ONE,ONE,-ONE, ONE,0,0, 0,-ONE,-ONE, ONE,ONE,ONE), 1, 1, 2*ONE);
    // Origin on the lo plane: face tried with t zero.
    add_row(mk(0,0,0, ONE,0,0, 0,-ONE,-ONE, ONE,ONE,ONE), 1, 1, 0);
    // Zero direction on the only reachable axis.
    add_row(mk(-2*ONE,0,0, 0,ONE,0, 0,-ONE,-ONE, ONE,ONE,ONE), 1, 0, 0);
    // Pointing away.
    add_row(mk(-2*ONE,0,0, -ONE,0,0, 0,-ONE,-ONE, ONE,ONE,ONE), 1, 0, 0);
    // Inverted box.
    add_row(mk(-2*ONE,0,0, ONE,0,0, ONE,ONE,ONE, 0,-ONE,-ONE), 0, 0, 0);
    add_row(mk(-2*ONE,-2*ONE,-2*ONE, ONE,ONE,ONE, 0,0,0, ONE,ONE,ONE), 0, 0, 0);
    add_row(mk(-3*ONE,-2*ONE,-5*ONE, 3,7,-9, 0,0,0, ONE,ONE,ONE), 0, 0, 0);
    add_row(mk(MN,MN,MN, MX,MX,MX, 0,0,0, ONE,ONE,ONE), 0, 0, 0);
    add_row(mk(MX,MX,MX, MN,MN,MN, MN,MN,MN, 0,0,0), 0, 0, 0);
    add_row(mk(MN,MX,0, MX,MN,1, MN,MN,MN, MX,MX,MX), 0, 0, 0);
    // Random part.
    for (int n = 0; n < N_RAND; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        for (int k = 0; k < 12; k++) it[k] = $urandom;
      end else begin
        for (int k = 0; k < 3; k++) begin
          c = small_coord(32'h0008_0000);
          s = $urandom_range(0, 32'h0004_0000);
          it[6+k] = c - s;
          it[9+k] = c + s;
          it[k] = c + small_coord(32'h000C_0000);
          if ($urandom_range(0, 9) == 0) it[k] = $urandom_range(0, 1) ? it[6+k] : it[9+k];
          it[3+k] = (c - $signed(it[k])) + small_coord(32'h0002_0000);
          if ($urandom_range(0, 7) == 0) it[3+k] = 0;
          if ($urandom_range(0, 15) == 0) it[3+k] = small_coord(8);
        end
        if (sel >= 92) begin
          tmp = it[6];
          it[6] = it[9];
          it[9] = tmp;
        end
      end
      add_row(it, 0, 0, 0);
    end
    n_items = items.size();
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH output %0d %s: got %h, expected %h", received, what, got, want);
  endtask

  // Sender: random gaps, holds data stable while stalled.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      sent = 0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        pending_hits.push_back(typed_row[sent] ? typed_res[sent] : nearest_hit(items[sent]));
        sent++;
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (sent < n_items) begin
        if (sent < n_items - QUIET && $urandom_range(0, 19) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= items[sent];
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each output transfer, stalls at random and once for long.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      received = 0;
      recv_gap = 0;
      long_hold = 0;
      held_long = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_hits.size() == 0) begin
          report_mismatch("without any pending item", m_tdata, 0);
        end else begin
          hit_res_t want;
          want = pending_hits.pop_front();
          if (m_tdata[0] !== want.hit) report_mismatch("hit", m_tdata[0], want.hit);
          if (m_tdata[DB:1] !== want.distance)
            report_mismatch("distance", m_tdata[DB:1], want.distance);
          if (m_tdata[0] === 1'b1) n_hits++;
        end
        received++;
      end
      if (!held_long && received == 300) begin
        held_long = 1'b1;
        long_hold = 400;
      end
      if (long_hold > 0) begin
        long_hold--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (sent < n_items - QUIET && $urandom_range(0, 19) == 0) begin
        recv_gap = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", WD_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    errors = 0;
    n_hits = 0;
    idle_cycles = 0;
    n_items = 0;
    build_stimulus();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (sent < n_items || pending_hits.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (m_tvalid) report_mismatch("output after the last expected item", m_tdata, 0);
    $display("Checked %0d rays (%0d hits), directed cases, random aims and raw words,",
             received, n_hits);
    $display("with random idling on both sides and one long output stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/rayaabb_pkg.sv
sv/rayaabb_front.sv
sv/rayaabb_fifo.sv
sv/rayaabb_div.sv
sv/rayaabb_back.sv
sv/ray_aabb_intersection.sv
dv/ray_aabb_intersection_tb.sv
